/* hdl/mbss_pkg.sv */
package mbss_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int ADDR_BITS_DEF   = 48;

	// per-position compare mode
	typedef enum logic [1:0] {
		MODE_ANY   = 2'd0,
		MODE_EXACT = 2'd1,
		MODE_LOW   = 2'd2,
		MODE_HIGH  = 2'd3
	} mode_t;

	// register index, byte address / 8
	typedef enum logic [2:0] {
		REG_PAT_LOW  = 3'd0,
		REG_PAT_HIGH = 3'd1,
		REG_MASKS    = 3'd2,
		REG_LENGTH   = 3'd3,
		REG_ALIGN    = 3'd4
	} reg_idx_t;

	// one window slot as it moves down the chain
	typedef struct packed {
		logic [7:0] data;
		logic       mark;
		logic       valid;
	} slot_t;

	function automatic logic position_ok(mode_t code, logic [7:0] pat, logic [7:0] b);
		logic [7:0] diff;
		logic       ok;
		diff = pat ^ b;
		case (code)
			MODE_EXACT: ok = (diff == 8'h00);
			MODE_LOW:   ok = (diff[3:0] == 4'h0);
			MODE_HIGH:  ok = (diff[7:4] == 4'h0);
			default:    ok = 1'b1;
		endcase
		return ok;
	endfunction

endpackage

/* hdl/mbss_cell.sv */
module mbss_cell import mbss_pkg::*; #(
	parameter int ADDRESS_BITS = ADDR_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_use,
	input  slot_t                   din,
	input  logic [ADDRESS_BITS-1:0] din_addr,
	input  logic [7:0]              pat_byte,
	input  mode_t                   pat_code,
	output slot_t                   dout,
	output logic [ADDRESS_BITS-1:0] dout_addr,
	output logic                    ok
);

	logic [7:0]              data_q;
	logic                    mark_q;
	logic                    valid_q;
	logic [ADDRESS_BITS-1:0] addr_q;

	// compare the slot this cell is about to take
	assign ok = !in_use || position_ok(pat_code, pat_byte, din.data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= din.data;
			mark_q <= din.mark;
			addr_q <= din_addr;
		end
	end

	assign dout.data  = data_q;
	assign dout.mark  = mark_q;
	assign dout.valid = valid_q;
	assign dout_addr  = addr_q;

endmodule

/* hdl/mbss_obuf.sv */
module mbss_obuf import mbss_pkg::*; #(
	parameter int DATA_W = ADDR_BITS_DEF + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] out_data
);

	logic [1:0]        cnt_q;
	logic [DATA_W-1:0] head_q;
	logic [DATA_W-1:0] tail_q;
	logic              pop;

	assign pop       = out_valid && out_ready;
	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// push only happens below full, so push with pop means one entry held
	always_ff @(posedge clk) begin
		if (push && pop) begin
			head_q <= push_data;
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= push_data;
			end else begin
				tail_q <= push_data;
			end
		end else if (pop) begin
			head_q <= tail_q;
		end
	end

endmodule

/* hdl/masked_byte_signature_scan.sv */
// Channel  | Direction | Carries
// s_*      | in        | one memory byte request: byte, address, start / region / end marks
// m_*      | out       | one result: found flag and start address of the first match
// apb      | in        | pattern, mask codes, length, alignment registers
//
// One byte is taken per cycle while s_tready is high, back to back; the compare runs
// on the byte as it enters the cell chain, so its result is registered at the same edge.
// A two-entry result buffer lets input flow while a result waits; s_tready drops
// only when both entries are held.
// Reset clears the window valid bits, phase, done flag, buffer and registers.
module masked_byte_signature_scan import mbss_pkg::*; #(
	parameter int PATTERN_MAX  = PATTERN_MAX_DEF,
	parameter int ADDRESS_BITS = ADDR_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// data_byte [7:0], byte_address above it, zero fill to bytes
	input  logic [((8+ADDRESS_BITS+7)/8)*8-1:0]     s_tdata,
	// scan_start [0], region_start [1]
	input  logic [1:0]                              s_tuser,
	input  logic                                    s_tlast,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// match_address from bit 0, zero fill to bytes
	output logic [((ADDRESS_BITS+7)/8)*8-1:0]       m_tdata,
	// found [0]
	output logic                                    m_tuser,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [5:0]                              paddr,
	input  logic [63:0]                             pwdata,
	output logic [63:0]                             prdata,
	output logic                                    pready
);

	localparam int TOP_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int OUT_W  = ((ADDRESS_BITS + 7) / 8) * 8;
	localparam int RES_W  = ADDRESS_BITS + 1;

	// configuration registers
	logic [63:0] pat_low_q;
	logic [63:0] pat_high_q;
	logic [31:0] masks_q;
	logic [4:0]  length_q;
	logic [15:0] align_q;

	reg_idx_t    reg_idx;
	logic        cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[5:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			masks_q    <= '0;
			length_q   <= 5'd1;
			align_q    <= 16'd1;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_PAT_LOW:  pat_low_q  <= pwdata;
				REG_PAT_HIGH: pat_high_q <= pwdata;
				REG_MASKS:    masks_q    <= pwdata[31:0];
				REG_LENGTH:   length_q   <= pwdata[4:0];
				REG_ALIGN:    align_q    <= pwdata[15:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PAT_LOW:  prdata = pat_low_q;
			REG_PAT_HIGH: prdata = pat_high_q;
			REG_MASKS:    prdata = {32'd0, masks_q};
			REG_LENGTH:   prdata = {59'd0, length_q};
			REG_ALIGN:    prdata = {48'd0, align_q};
			default:      prdata = 64'd0;
		endcase
	end

	// unpack the input request
	logic [7:0]              in_byte;
	logic [ADDRESS_BITS-1:0] in_addr;
	logic                    in_scan_start;
	logic                    in_region_start;
	logic                    in_scan_end;

	assign in_byte         = s_tdata[7:0];
	assign in_addr         = s_tdata[8 +: ADDRESS_BITS];
	assign in_scan_start   = s_tuser[0];
	assign in_region_start = s_tuser[1];
	assign in_scan_end     = s_tlast;

	// scan control
	logic        done_q;
	logic [15:0] phase_q;
	logic        acc;
	logic        proc;
	logic        clear;
	logic        hit;
	logic        res_push;
	logic        buf_full;
	logic [15:0] phase_eff;
	logic [15:0] align_eff;
	logic [16:0] phase_inc;

	assign s_tready  = !buf_full;
	assign acc       = s_tvalid && s_tready;
	// a scan start reopens a finished scan
	assign proc      = acc && (in_scan_start || !done_q);
	assign clear     = in_scan_start || in_region_start;
	assign phase_eff = clear ? 16'd0 : phase_q;
	assign align_eff = (align_q == 16'd0) ? 16'd1 : align_q;
	assign phase_inc = {1'b0, phase_eff} + 17'd1;
	assign res_push  = proc && (hit || in_scan_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			phase_q <= '0;
		end else begin
			if (acc) begin
				// hold done until the next scan start; set on any result
				done_q <= (done_q && !in_scan_start) || res_push;
			end
			if (proc) begin
				// wrap when the step is reached; a shrunk alignment wraps too
				phase_q <= (phase_inc >= {1'b0, align_eff}) ? 16'd0 : phase_inc[15:0];
			end
		end
	end

	// effective length and the slot that holds the candidate start
	logic [4:0]       len_eff;
	logic [TOP_W-1:0] top;

	assign len_eff = (length_q > 5'(PATTERN_MAX)) ? 5'(PATTERN_MAX) : length_q;
	assign top     = (len_eff == 5'd0) ? '0 : TOP_W'(len_eff - 5'd1);

	// pattern bytes and modes per position
	logic [7:0] pat_byte [PATTERN_MAX];
	mode_t      pat_mode [PATTERN_MAX];

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pat
		if (i < 8) begin : g_lo
			assign pat_byte[i] = pat_low_q[8*i +: 8];
		end else begin : g_hi
			assign pat_byte[i] = pat_high_q[8*(i-8) +: 8];
		end
		assign pat_mode[i] = mode_t'(masks_q[2*i +: 2]);
	end

	// cell chain: slot 0 takes the new byte, slot k takes slot k-1
	slot_t                   slot_in   [PATTERN_MAX];
	logic [ADDRESS_BITS-1:0] addr_in   [PATTERN_MAX];
	slot_t                   slot_out  [PATTERN_MAX];
	logic [ADDRESS_BITS-1:0] addr_out  [PATTERN_MAX];
	logic [PATTERN_MAX-1:0]  ok_vec;
	logic [PATTERN_MAX-1:0]  valid_vec;

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_chain
		logic [TOP_W-1:0] pos;
		logic             in_use;

		if (k == 0) begin : g_head
			assign slot_in[k].data  = in_byte;
			assign slot_in[k].mark  = (phase_eff == 16'd0);
			assign slot_in[k].valid = 1'b1;
			assign addr_in[k]       = in_addr;
		end else begin : g_body
			// drop the older bytes on a region or scan start
			assign slot_in[k].data  = slot_out[k-1].data;
			assign slot_in[k].mark  = slot_out[k-1].mark;
			assign slot_in[k].valid = slot_out[k-1].valid && !clear;
			assign addr_in[k]       = addr_out[k-1];
		end

		assign pos    = top - TOP_W'(k);
		assign in_use = ({27'd0, len_eff} > k);

		mbss_cell #(
			.ADDRESS_BITS(ADDRESS_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (proc),
			.in_use    (in_use),
			.din       (slot_in[k]),
			.din_addr  (addr_in[k]),
			.pat_byte  (pat_byte[pos]),
			.pat_code  (pat_mode[pos]),
			.dout      (slot_out[k]),
			.dout_addr (addr_out[k]),
			.ok        (ok_vec[k])
		);

		assign valid_vec[k] = slot_out[k].valid;
	end

	// the start slot must be filled and aligned, every used position must agree
	assign hit = (&ok_vec) && slot_in[top].valid && slot_in[top].mark;

	// result buffer
	logic [RES_W-1:0] res_data;
	logic [RES_W-1:0] head_data;

	assign res_data = hit ? {1'b1, addr_in[top]} : {1'b0, {ADDRESS_BITS{1'b0}}};

	mbss_obuf #(
		.DATA_W(RES_W)
	) u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_data),
		.full      (buf_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (head_data)
	);

	assign m_tuser = head_data[ADDRESS_BITS];
	assign m_tdata = OUT_W'(head_data[ADDRESS_BITS-1:0]);

	// after any result the scan stays closed
	a_done_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> done_q)
		else $error("scan not closed after a result");

	// a closed scan moves the chain only on a scan start
	a_closed_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && done_q) |-> in_scan_start)
		else $error("byte processed in a closed scan");

	// filled slots are contiguous from slot 0
	a_fill_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec >> 1) & ~valid_vec) == '0)
		else $error("window fill has a gap");

	// no result is pushed into a full buffer
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		buf_full |-> !res_push)
		else $error("result pushed into full buffer");

endmodule
